[hw/rtl/lzr_pkg.sv]
package lzr_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int LOOKAHEAD = 18;
  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam logic [ADDR_W-1:0] WP_RESET = ADDR_W'(RING_DEPTH - LOOKAHEAD);
  localparam int FILL_W = ADDR_W + 1;
  localparam logic [2:0] HEADER_BYTES = 3'd4;
  localparam logic [4:0] MIN_MATCH = 5'd3;
  localparam logic [3:0] FLAGS_PER_CONTROL = 4'd8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic {
    ST_PARSE,
    ST_COPY
  } eng_state_t;

endpackage

[hw/rtl/lzss_ring_decompressor.sv]
// LZSS decompressor with a 4096-byte history ring.
// The comp channel takes one compressed byte per beat; stream_start on the
// first header byte restarts the parser and empties the history. The plain
// channel delivers one decompressed byte per beat, with is_last set on the
// byte that completes the length stated in the four-byte header.
// Header, control and first reference bytes are taken without issuing.
// A literal is issued, then written to the ring and queued from the write
// stage; no input is taken while that stage is full. A back-reference of
// n bytes issues one byte per cycle while the output queue has room, paced
// by the single read and single write port of the ring; no input is taken
// until its last byte has left the write stage.
// History is tracked by a fill count, so neither reset nor stream_start
// needs a clearing pass; unwritten entries read as zero.
// A four-beat output queue sits between the core and the plain channel.
// When the receiver stalls, the queue fills and the core stops issuing
// bytes and accepting input; nothing is lost.
// Reset is synchronous and returns the parser to the start of a header.
module lzss_ring_decompressor (
  input  logic               clk,
  input  logic               rst,
  input  logic               comp_valid,
  output logic               comp_ready,
  input  lzr_pkg::in_item_t  comp_data,
  output logic               plain_valid,
  input  logic               plain_ready,
  output lzr_pkg::out_item_t plain_data
);

  lzr_pkg::ram_req_t           ram_req;
  logic [7:0]                  ram_rd_data;
  logic [lzr_pkg::QCNT_W-1:0]  q_count;
  logic                        q_push;
  lzr_pkg::out_item_t          q_data;

  lzr_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (comp_valid),
    .in_ready    (comp_ready),
    .in_data     (comp_data),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_data      (q_data),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  lzr_ring_ram u_ring (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  lzr_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .count     (q_count),
    .valid     (plain_valid),
    .ready     (plain_ready),
    .data      (plain_data)
  );

endmodule

[hw/rtl/lzr_ring_ram.sv]
module lzr_ring_ram (
  input  logic              clk,
  input  lzr_pkg::ram_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [lzr_pkg::RING_DEPTH];

  // Read-first: a read of the entry being written returns the old byte.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

[hw/rtl/lzr_out_queue.sv]
module lzr_out_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  lzr_pkg::out_item_t           push_data,
  output logic [lzr_pkg::QCNT_W-1:0]   count,
  output logic                         valid,
  input  logic                         ready,
  output lzr_pkg::out_item_t           data
);

  localparam int QCNT_W = lzr_pkg::QCNT_W;

  lzr_pkg::out_item_t entries [lzr_pkg::QUEUE_DEPTH];
  logic [lzr_pkg::QPTR_W-1:0] wr_ptr;
  logic [lzr_pkg::QPTR_W-1:0] rd_ptr;
  logic pop;

  assign valid = (count != '0);
  assign data  = entries[rd_ptr];
  assign pop   = valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[hw/rtl/lzr_engine.sv]
module lzr_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lzr_pkg::in_item_t          in_data,
  input  logic [lzr_pkg::QCNT_W-1:0] q_count,
  output logic                       q_push,
  output lzr_pkg::out_item_t         q_data,
  output lzr_pkg::ram_req_t          ram_req,
  input  logic [7:0]                 ram_rd_data
);

  localparam int ADDR_W = lzr_pkg::ADDR_W;
  localparam int FILL_W = lzr_pkg::FILL_W;
  localparam int QCNT_W = lzr_pkg::QCNT_W;

  lzr_pkg::eng_state_t state, state_next;

  logic [2:0]        hdr_cnt, hdr_cnt_next;
  logic [31:0]       rem, rem_next;
  logic [7:0]        flag_byte, flag_byte_next;
  logic [3:0]        flag_idx, flag_idx_next;
  logic [7:0]        first_ref, first_ref_next;
  logic              awaiting, awaiting_next;
  logic [ADDR_W-1:0] wp, wp_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [ADDR_W-1:0] ref_dist, ref_dist_next;
  logic [4:0]        copy_left, copy_left_next;

  // Write stage: one byte that was issued in the previous cycle.
  logic              s2_valid;
  logic              s2_copy;
  logic [7:0]        s2_lit;
  logic              s2_last;
  logic [ADDR_W-1:0] s2_waddr;
  logic              s2_fwd;
  logic [7:0]        s2_fwd_data;
  logic              s2_hit;
  logic [7:0]        s2_byte;

  logic              accept;
  logic              room;
  logic              start;
  logic [2:0]        eff_hdr;
  logic [31:0]       eff_rem;
  logic [3:0]        eff_fi;
  logic [7:0]        eff_flags;
  logic              eff_await;
  logic [ADDR_W-1:0] eff_wp;
  logic [FILL_W-1:0] eff_fill;
  logic [7:0]        b;

  logic              iss_valid;
  logic              iss_copy;
  logic              iss_last;
  logic [ADDR_W-1:0] iss_raddr;
  logic [ADDR_W-1:0] iss_off;
  logic              iss_hit;
  logic              iss_fwd;

  assign room     = ({1'b0, q_count} + (QCNT_W + 1)'(s2_valid))
                    < (QCNT_W + 1)'(lzr_pkg::QUEUE_DEPTH);
  assign in_ready = (state == lzr_pkg::ST_PARSE) && !s2_valid && room;
  assign accept   = in_valid && in_ready;
  assign start    = accept && in_data.stream_start;
  assign b        = in_data.in_byte;

  assign iss_raddr = wp - ref_dist;
  // Writes since the last clear run contiguously up from the reset pointer,
  // so an entry holds stream data exactly when its offset is below the fill.
  assign iss_off   = iss_raddr - lzr_pkg::WP_RESET;
  assign iss_hit   = fill[ADDR_W] || (iss_off < fill[ADDR_W-1:0]);
  assign iss_fwd   = s2_valid && (iss_raddr == s2_waddr);

  always_comb begin
    if (!s2_copy) begin
      s2_byte = s2_lit;
    end else if (s2_fwd) begin
      s2_byte = s2_fwd_data;
    end else if (s2_hit) begin
      s2_byte = ram_rd_data;
    end else begin
      s2_byte = '0;
    end
  end

  assign ram_req.we    = s2_valid;
  assign ram_req.waddr = s2_waddr;
  assign ram_req.wdata = s2_byte;
  assign ram_req.raddr = iss_raddr;

  assign q_push        = s2_valid;
  assign q_data.out_byte = s2_byte;
  assign q_data.is_last  = s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzr_pkg::ST_PARSE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    eff_hdr   = start ? 3'd0 : hdr_cnt;
    eff_rem   = start ? 32'd0 : rem;
    eff_fi    = start ? lzr_pkg::FLAGS_PER_CONTROL : flag_idx;
    eff_flags = start ? 8'd0 : flag_byte;
    eff_await = start ? 1'b0 : awaiting;
    eff_wp    = start ? lzr_pkg::WP_RESET : wp;
    eff_fill  = start ? '0 : fill;

    state_next     = state;
    hdr_cnt_next   = eff_hdr;
    rem_next       = eff_rem;
    flag_byte_next = eff_flags;
    flag_idx_next  = eff_fi;
    first_ref_next = first_ref;
    awaiting_next  = eff_await;
    wp_next        = eff_wp;
    ref_dist_next  = ref_dist;
    copy_left_next = copy_left;
    iss_valid      = 1'b0;
    iss_copy       = 1'b0;

    unique case (state)
      lzr_pkg::ST_PARSE: begin
        if (accept) begin
          priority if (eff_hdr < lzr_pkg::HEADER_BYTES) begin
            rem_next     = eff_rem | (32'(b) << {eff_hdr[1:0], 3'b000});
            hdr_cnt_next = eff_hdr + 3'd1;
          end else if (eff_rem == 32'd0) begin
            // Stream complete: surplus bytes are dropped.
          end else if (eff_fi >= lzr_pkg::FLAGS_PER_CONTROL) begin
            flag_byte_next = b;
            flag_idx_next  = 4'd0;
          end else if (!eff_flags[eff_fi[2:0]]) begin
            flag_idx_next = eff_fi + 4'd1;
            iss_valid     = 1'b1;
          end else if (!eff_await) begin
            first_ref_next = b;
            awaiting_next  = 1'b1;
          end else begin
            awaiting_next  = 1'b0;
            flag_idx_next  = eff_fi + 4'd1;
            ref_dist_next  = {b[3:0], first_ref};
            copy_left_next = {1'b0, b[7:4]} + lzr_pkg::MIN_MATCH;
            state_next     = lzr_pkg::ST_COPY;
          end
        end
      end
      lzr_pkg::ST_COPY: begin
        if (room) begin
          iss_valid      = 1'b1;
          iss_copy       = 1'b1;
          copy_left_next = copy_left - 5'd1;
          if (copy_left == 5'd1 || rem == 32'd1) begin
            state_next = lzr_pkg::ST_PARSE;
          end
        end
      end
      default: begin
        state_next = lzr_pkg::ST_PARSE;
      end
    endcase

    iss_last = (eff_rem == 32'd1);
    if (iss_valid) begin
      wp_next  = eff_wp + 1'b1;
      rem_next = eff_rem - 32'd1;
    end

    fill_next = eff_fill + FILL_W'(s2_valid && !eff_fill[ADDR_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_cnt   <= 3'd0;
      rem       <= 32'd0;
      flag_byte <= 8'd0;
      flag_idx  <= lzr_pkg::FLAGS_PER_CONTROL;
      first_ref <= 8'd0;
      awaiting  <= 1'b0;
      wp        <= lzr_pkg::WP_RESET;
      fill      <= '0;
      s2_valid  <= 1'b0;
    end else begin
      hdr_cnt   <= hdr_cnt_next;
      rem       <= rem_next;
      flag_byte <= flag_byte_next;
      flag_idx  <= flag_idx_next;
      first_ref <= first_ref_next;
      awaiting  <= awaiting_next;
      wp        <= wp_next;
      fill      <= fill_next;
      s2_valid  <= iss_valid;
    end
  end

  always_ff @(posedge clk) begin
    ref_dist  <= ref_dist_next;
    copy_left <= copy_left_next;
    if (iss_valid) begin
      s2_copy     <= iss_copy;
      s2_lit      <= b;
      s2_last     <= iss_last;
      s2_waddr    <= eff_wp;
      s2_fwd      <= iss_fwd;
      s2_fwd_data <= s2_byte;
      s2_hit      <= iss_hit;
    end
  end

endmodule

[test/lzss_ring_decompressor_tb.sv]
module lzss_ring_decompressor_tb;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_BEATS = 86;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_TRICKLE,
    RX_PAIRS
  } rx_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       ss;
    logic       typed;
    logic [7:0] want_byte;
    logic       want_last;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               comp_valid;
  logic               comp_ready;
  lzr_pkg::in_item_t  comp_data;
  logic               plain_valid;
  logic               plain_ready;
  lzr_pkg::out_item_t plain_data;

  // Decoder image: history ring and parser position.
  logic [7:0]  hist [lzr_pkg::RING_DEPTH];
  logic [11:0] hist_wp;
  logic [2:0]  hdr_taken;
  logic [31:0] left_to_emit;
  logic [7:0]  ctrl_flags;
  logic [3:0]  ctrl_pos;
  logic [7:0]  ref_lo;
  logic        ref_half;

  lzr_pkg::out_item_t plain_expect [$];
  lzr_pkg::out_item_t got_beat;
  lzr_pkg::out_item_t want_beat;
  logic               pin_typed;
  lzr_pkg::out_item_t pin_want;

  int unsigned taken_beats;
  int unsigned ignored_beats;
  int unsigned stream_count;
  int unsigned plain_checked;
  int unsigned last_marks;
  int unsigned err_count;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  int unsigned rx_tick;
  int unsigned rx_left;
  rx_mode_t    rx_mode;

  // Stream with no start mark after reset, then an empty stream, then the
  // longest stated length with the farthest and longest reference.
  dir_row_t dir_rows [24] = '{
    '{8'h02, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h02, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
    '{8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h7E, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hC3, 1'b0, 1'b1, 8'hC3, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h13, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h20, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  lzss_ring_decompressor DUT (
    .clk         (clk),
    .rst         (rst),
    .comp_valid  (comp_valid),
    .comp_ready  (comp_ready),
    .comp_data   (comp_data),
    .plain_valid (plain_valid),
    .plain_ready (plain_ready),
    .plain_data  (plain_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_history();
    int a;
    for (a = 0; a < lzr_pkg::RING_DEPTH; a++) hist[a] = 8'h00;
    hist_wp = lzr_pkg::WP_RESET;
    hdr_taken = 3'd0;
    left_to_emit = 32'd0;
    ctrl_flags = 8'h00;
    ctrl_pos = lzr_pkg::FLAGS_PER_CONTROL;
    ref_lo = 8'h00;
    ref_half = 1'b0;
  endfunction

  function automatic void emit_plain(input logic [7:0] v);
    lzr_pkg::out_item_t o;
    hist[hist_wp] = v;
    hist_wp = hist_wp + 12'd1;
    left_to_emit = left_to_emit - 32'd1;
    o.out_byte = v;
    o.is_last = (left_to_emit == 32'd0);
    plain_expect.push_back(o);
  endfunction

  // Advances the decoder image by one compressed beat and queues the plain
  // bytes it yields. Returns 0 when the beat is ignored.
  function automatic bit decode_beat(input lzr_pkg::in_item_t it);
    logic [11:0] back_dist;
    int unsigned run;
    int unsigned k;
    if (it.stream_start) clear_history();
    if (hdr_taken < lzr_pkg::HEADER_BYTES) begin
      left_to_emit = left_to_emit | (32'(it.in_byte) << (8 * hdr_taken));
      hdr_taken = hdr_taken + 3'd1;
      return 1'b1;
    end
    if (left_to_emit == 32'd0) return 1'b0;
    if (ctrl_pos >= lzr_pkg::FLAGS_PER_CONTROL) begin
      ctrl_flags = it.in_byte;
      ctrl_pos = 4'd0;
      return 1'b1;
    end
    if (!ctrl_flags[ctrl_pos[2:0]]) begin
      ctrl_pos = ctrl_pos + 4'd1;
      emit_plain(it.in_byte);
      return 1'b1;
    end
    if (!ref_half) begin
      ref_lo = it.in_byte;
      ref_half = 1'b1;
      return 1'b1;
    end
    ref_half = 1'b0;
    ctrl_pos = ctrl_pos + 4'd1;
    back_dist = {it.in_byte[3:0], ref_lo};
    run = it.in_byte[7:4] + lzr_pkg::MIN_MATCH;
    // The read address follows the write pointer, so short distances repeat.
    for (k = 0; k < run && left_to_emit != 32'd0; k++)
      emit_plain(hist[12'(hist_wp - back_dist)]);
    return 1'b1;
  endfunction

  task automatic push_comp(input lzr_pkg::in_item_t it);
    comp_data <= it;
    comp_valid <= 1'b1;
    @(posedge clk);
    while (!comp_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      comp_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  // Receiver: switches between stall styles at random intervals.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 60);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:    plain_ready <= 1'b1;
      RX_COIN:    plain_ready <= 1'($urandom_range(0, 1));
      RX_TRICKLE: plain_ready <= (rx_tick % 5 == 0);
      default:    plain_ready <= rx_tick[1];
    endcase
    rx_tick++;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (comp_valid && comp_ready) begin
        if (decode_beat(comp_data)) taken_beats++;
        else ignored_beats++;
        if (comp_data.stream_start) stream_count++;
        if (pin_typed) begin
          void'(plain_expect.pop_back());
          plain_expect.push_back(pin_want);
        end
      end
      if (plain_valid && plain_ready) begin
        got_beat = plain_data;
        if (plain_expect.size() == 0) begin
          $display("%0t: plain beat with nothing expected: byte %02h last %0b",
                   $time, got_beat.out_byte, got_beat.is_last);
          err_count++;
        end else begin
          want_beat = plain_expect.pop_front();
          plain_checked++;
          if (got_beat.is_last) last_marks++;
          if (got_beat.out_byte !== want_beat.out_byte ||
              got_beat.is_last !== want_beat.is_last) begin
            $display("%0t: plain mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, want_beat.out_byte, want_beat.is_last,
                     got_beat.out_byte, got_beat.is_last);
            err_count++;
          end
        end
      end
      if ((comp_valid && comp_ready) || (plain_valid && plain_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles, %0d plain bytes still expected",
                   $time, quiet_cycles, plain_expect.size());
          $display("lzss_ring_decompressor regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned k;
    int unsigned goal;
    int unsigned pick;
    int unsigned sel;
    int unsigned body;
    int unsigned cut;
    logic [31:0] stated_len;
    logic [11:0] span;
    logic [3:0]  ref_far;
    logic [7:0]  nxt;

    rst = 1'b1;
    comp_valid = 1'b0;
    comp_data = '0;
    plain_ready = 1'b0;
    pin_typed = 1'b0;
    pin_want = '0;
    taken_beats = 0;
    ignored_beats = 0;
    stream_count = 0;
    plain_checked = 0;
    last_marks = 0;
    err_count = 0;
    quiet_cycles = 0;
    burst_left = 0;
    rx_tick = 0;
    rx_left = 0;
    rx_mode = RX_OPEN;
    ref_far = 4'd0;
    clear_history();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(dir_rows); i++) begin
      pin_typed = dir_rows[i].typed;
      pin_want = '{out_byte: dir_rows[i].want_byte, is_last: dir_rows[i].want_last};
      push_comp('{in_byte: dir_rows[i].b, stream_start: dir_rows[i].ss});
    end
    pin_typed = 1'b0;

    // Mostly well-formed streams whose next byte is chosen from where the
    // parser stands; some are cut short, some followed by surplus or noise.
    goal = taken_beats + ignored_beats + RANDOM_BEATS;
    while (taken_beats + ignored_beats < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) stated_len = 32'd0;
        else if (sel < 15) stated_len = $urandom_range(1, 40);
        else if (sel < 18) stated_len = $urandom_range(41, 200);
        else if (sel == 18) stated_len = $urandom_range(1, 8);
        else stated_len = $urandom;
        for (k = 0; k < 4; k++)
          push_comp('{in_byte: stated_len[8*k +: 8], stream_start: (k == 0)});
        body = 0;
        cut = (pick == 7) ? $urandom_range(1, 24) : 90;
        while (left_to_emit != 32'd0 && body < cut &&
               taken_beats + ignored_beats < goal) begin
          if (ctrl_pos >= lzr_pkg::FLAGS_PER_CONTROL) begin
            nxt = 8'($urandom_range(0, 255));
          end else if (ref_half) begin
            nxt = {4'($urandom_range(0, 15)), ref_far};
          end else if (!ctrl_flags[ctrl_pos[2:0]]) begin
            nxt = 8'($urandom_range(0, 255));
          end else begin
            sel = $urandom_range(0, 9);
            if (sel == 0) span = 12'd0;
            else if (sel < 8) span = 12'($urandom_range(1, 24));
            else span = 12'($urandom_range(0, 4095));
            ref_far = span[11:8];
            nxt = span[7:0];
          end
          push_comp('{in_byte: nxt, stream_start: 1'b0});
          body++;
        end
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 4))
          push_comp('{in_byte: 8'($urandom_range(0, 255)), stream_start: 1'b0});
      end else begin
        repeat ($urandom_range(1, 6))
          push_comp('{in_byte: 8'($urandom_range(0, 255)),
                      stream_start: ($urandom_range(0, 3) == 0)});
      end
    end
    comp_valid <= 1'b0;

    while (plain_expect.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (plain_expect.size() != 0) begin
      $display("%0t: %0d expected plain bytes never arrived", $time, plain_expect.size());
      err_count++;
    end
    $display("Run covered %0d compressed beats taken and %0d ignored across %0d stream starts.",
             taken_beats, ignored_beats, stream_count);
    $display("Checked %0d plain bytes, %0d of them marked as the end of a stream.",
             plain_checked, last_marks);
    if (err_count == 0) begin
      $display("lzss_ring_decompressor regression: pass");
    end else begin
      $display("lzss_ring_decompressor regression: fail");
    end
    $finish;
  end

endmodule

[lzss_ring_decompressor.f]
hw/rtl/lzr_pkg.sv
hw/rtl/lzr_ring_ram.sv
hw/rtl/lzr_out_queue.sv
hw/rtl/lzr_engine.sv
hw/rtl/lzss_ring_decompressor.sv
test/lzss_ring_decompressor_tb.sv
